>>> rtl/core/ax25fhp_pkg.sv
`default_nettype none
package ax25fhp_pkg;

	localparam int LEN_W = 11;
	localparam int IDX_W = 11;
	localparam int VAL_W = 14;
	localparam int MAX_FRAME_BYTES_DEF = 2048;
	localparam int MAX_TOKENS = 3;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HDR,
		PH_COMP,
		PH_NORM,
		PH_ADDR,
		PH_CTRL,
		PH_PID,
		PH_DATA
	} phase_t;

	localparam logic [3:0] KIND_DEST_CHAR = 4'd0;
	localparam logic [3:0] KIND_DEST_SSID = 4'd1;
	localparam logic [3:0] KIND_SRC_CHAR  = 4'd2;
	localparam logic [3:0] KIND_SRC_SSID  = 4'd3;
	localparam logic [3:0] KIND_VIA_CHAR  = 4'd4;
	localparam logic [3:0] KIND_VIA_SSID  = 4'd5;
	localparam logic [3:0] KIND_QSO       = 4'd6;
	localparam logic [3:0] KIND_CONTROL   = 4'd7;
	localparam logic [3:0] KIND_PID       = 4'd8;
	localparam logic [3:0] KIND_PAYLOAD   = 4'd9;

	localparam logic [3:0] FK_I     = 4'd0;
	localparam logic [3:0] FK_RR    = 4'd1;
	localparam logic [3:0] FK_RNR   = 4'd2;
	localparam logic [3:0] FK_REJ   = 4'd3;
	localparam logic [3:0] FK_S_UNK = 4'd4;
	localparam logic [3:0] FK_UI    = 4'd5;
	localparam logic [3:0] FK_SABM  = 4'd6;
	localparam logic [3:0] FK_DISC  = 4'd7;
	localparam logic [3:0] FK_DM    = 4'd8;
	localparam logic [3:0] FK_UA    = 4'd9;
	localparam logic [3:0] FK_FRMR  = 4'd10;
	localparam logic [3:0] FK_U_UNK = 4'd11;

	localparam logic [7:0] U_UI   = 8'h03;
	localparam logic [7:0] U_SABM = 8'h2f;
	localparam logic [7:0] U_DISC = 8'h43;
	localparam logic [7:0] U_DM   = 8'h0f;
	localparam logic [7:0] U_UA   = 8'h63;
	localparam logic [7:0] U_FRMR = 8'h87;

	localparam logic [3:0] S_RR  = 4'h1;
	localparam logic [3:0] S_RNR = 4'h5;
	localparam logic [3:0] S_REJ = 4'h9;

	localparam logic [7:0] SPACE_SHIFTED = 8'h40;
	localparam logic [VAL_W-1:0] COMP_CHAR_OFFSET = 14'h20;

	typedef struct packed {
		logic [3:0]       kind;
		logic [VAL_W-1:0] value;
		logic [3:0]       frame_kind;
		logic [2:0]       recv_seq;
		logic [2:0]       send_seq;
		logic             poll_final;
		logic             version_one;
		logic             is_command;
		logic [7:0]       control_raw;
	} token_t;

	typedef struct packed {
		logic [1:0]  count;
		token_t [MAX_TOKENS-1:0] toks;
	} group_t;

	function automatic token_t mk_token(input logic [3:0] kind, input logic [VAL_W-1:0] value);
		token_t t;
		t = '0;
		t.kind = kind;
		t.value = value;
		return t;
	endfunction

	function automatic token_t mk_control(input logic [7:0] c, input logic ovs, input logic cmd);
		token_t t;
		logic [7:0] ru;
		t = mk_token(KIND_CONTROL, {6'd0, c});
		ru = c & 8'hef;
		t.poll_final = c[4];
		t.version_one = ovs;
		t.is_command = ovs ? 1'b0 : cmd;
		if (!c[0]) begin
			t.frame_kind = FK_I;
			t.recv_seq = c[7:5];
			t.send_seq = c[3:1];
			t.control_raw = c;
		end else if (c[1]) begin
			t.control_raw = ru;
			case (ru)
				U_UI:    t.frame_kind = FK_UI;
				U_SABM:  t.frame_kind = FK_SABM;
				U_DISC:  t.frame_kind = FK_DISC;
				U_DM:    t.frame_kind = FK_DM;
				U_UA:    t.frame_kind = FK_UA;
				U_FRMR:  t.frame_kind = FK_FRMR;
				default: t.frame_kind = FK_U_UNK;
			endcase
		end else begin
			t.control_raw = {4'd0, c[3:0]};
			t.recv_seq = c[7:5];
			case (c[3:0])
				S_RR:    t.frame_kind = FK_RR;
				S_RNR:   t.frame_kind = FK_RNR;
				S_REJ:   t.frame_kind = FK_REJ;
				default: t.frame_kind = FK_S_UNK;
			endcase
		end
		return t;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/ax25fhp_if.sv
`default_nettype none
interface ax25fhp_byte_if;
	logic                          valid;
	logic                          ready;
	logic [7:0]                    data_byte;
	logic                          first_of_frame;
	logic [ax25fhp_pkg::LEN_W-1:0] frame_length;

	modport source (output valid, data_byte, first_of_frame, frame_length, input ready);
	modport sink (input valid, data_byte, first_of_frame, frame_length, output ready);
endinterface

interface ax25fhp_token_if;
	logic                          valid;
	logic                          ready;
	logic [3:0]                    token_kind;
	logic [ax25fhp_pkg::VAL_W-1:0] token_value;
	logic [3:0]                    frame_kind;
	logic [2:0]                    recv_seq;
	logic [2:0]                    send_seq;
	logic                          poll_final;
	logic                          version_one;
	logic                          is_command;
	logic [7:0]                    control_raw;
	logic                          last_of_run;

	modport source (output valid, token_kind, token_value, frame_kind, recv_seq, send_seq,
		poll_final, version_one, is_command, control_raw, last_of_run, input ready);
	modport sink (input valid, token_kind, token_value, frame_kind, recv_seq, send_seq,
		poll_final, version_one, is_command, control_raw, last_of_run, output ready);
endinterface
`default_nettype wire

>>> rtl/core/ax25fhp_parse.sv
`default_nettype none
module ax25fhp_parse #(
	parameter int MAX_FRAME_BYTES = ax25fhp_pkg::MAX_FRAME_BYTES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          accept,
	input  wire logic [7:0]                    data_byte,
	input  wire logic                          first_of_frame,
	input  wire logic [ax25fhp_pkg::LEN_W-1:0] frame_length,
	output ax25fhp_pkg::group_t                grp
);
	import ax25fhp_pkg::*;

	localparam int LenCap = (MAX_FRAME_BYTES > 2047) ? 2047 : MAX_FRAME_BYTES;

	logic [IDX_W-1:0] idx_q, e_idx, n_idx;
	logic [LEN_W-1:0] bl_q, e_bl, n_bl, len_c;
	phase_t           ph_q, e_ph, n_ph;
	logic [7:0]       held_q, n_held, fbc_q, n_fbc;
	logic             ovs_q, e_ovs, n_ovs;
	logic             cmd_q, e_cmd, n_cmd;
	logic             aeb_q, e_aeb, n_aeb;
	logic [2:0]       boff_q, e_boff, n_boff;
	logic [VAL_W-1:0] qso_q, e_qso, n_qso;
	token_t [MAX_TOKENS-1:0] t;
	logic [1:0]       cnt;
	logic [7:0]       b;
	logic [5:0]       cc [2];
	logic [2:0]       ncc;

	assign b = data_byte;
	assign len_c = (frame_length > LenCap[LEN_W-1:0]) ? LenCap[LEN_W-1:0] : frame_length;

	always_comb begin
		e_bl = bl_q;
		e_idx = idx_q;
		e_ph = ph_q;
		e_ovs = ovs_q;
		e_cmd = cmd_q;
		e_aeb = aeb_q;
		e_boff = boff_q;
		e_qso = qso_q;
		if (first_of_frame) begin
			e_bl = len_c;
			e_idx = '0;
			e_ovs = 1'b1;
			e_cmd = 1'b0;
			e_aeb = 1'b0;
			e_boff = '0;
			e_qso = '0;
			e_ph = (len_c < LEN_W'(8)) ? PH_IDLE : PH_HDR;
		end
		n_bl = e_bl;
		n_idx = e_idx;
		n_ph = e_ph;
		n_ovs = e_ovs;
		n_cmd = e_cmd;
		n_aeb = e_aeb;
		n_boff = e_boff;
		n_qso = e_qso;
		n_held = held_q;
		n_fbc = fbc_q;
		t = '0;
		cnt = 2'd0;
		cc[0] = '0;
		cc[1] = '0;
		ncc = '0;
		if (e_ph == PH_IDLE || e_bl == '0) begin
			n_ph = PH_IDLE;
		end else begin
			case (e_ph)
				PH_HDR: begin
					if (e_idx == '0) begin
						n_fbc = b;
					end else if (b[0]) begin
						n_ovs = 1'b0;
						n_cmd = b[1];
						n_qso = {fbc_q, b[7:2]};
						n_ph = PH_COMP;
					end else if (e_bl < LEN_W'(14)) begin
						n_ph = PH_IDLE;
					end else begin
						if ((fbc_q & 8'hfe) != SPACE_SHIFTED) begin
							t[cnt] = mk_token(KIND_DEST_CHAR, {7'd0, fbc_q[7:1]});
							cnt = cnt + 2'd1;
						end
						if ((b & 8'hfe) != SPACE_SHIFTED) begin
							t[cnt] = mk_token(KIND_DEST_CHAR, {7'd0, b[7:1]});
							cnt = cnt + 2'd1;
						end
						n_ph = PH_NORM;
					end
				end
				PH_COMP: begin
					if (e_idx == IDX_W'(2) || e_idx == IDX_W'(5)) begin
						cc[0] = b[7:2];
						ncc = 3'd1;
					end else if (e_idx == IDX_W'(3)) begin
						cc[0] = {held_q[1:0], b[7:4]};
						ncc = 3'd1;
					end else if (e_idx == IDX_W'(4)) begin
						cc[0] = {held_q[3:0], b[7:6]};
						cc[1] = b[5:0];
						ncc = 3'd2;
					end else begin
						cc[0] = {held_q[1:0], b[7:4]};
						ncc = 3'd1;
						n_ph = PH_CTRL;
					end
					for (int i = 0; i < 2; i++) begin
						if (i < int'(ncc) && cc[i] != '0) begin
							t[cnt] = mk_token(KIND_DEST_CHAR, {8'd0, cc[i]} + COMP_CHAR_OFFSET);
							cnt = cnt + 2'd1;
						end
					end
					if (n_ph == PH_CTRL) begin
						t[cnt] = mk_token(KIND_DEST_SSID, {10'd0, b[3:0]});
						cnt = cnt + 2'd1;
						t[cnt] = mk_token(KIND_QSO, e_qso);
						cnt = cnt + 2'd1;
					end
				end
				PH_NORM: begin
					if (e_idx < IDX_W'(6)) begin
						if ((b & 8'hfe) != SPACE_SHIFTED) begin
							t[0] = mk_token(KIND_DEST_CHAR, {7'd0, b[7:1]});
							cnt = 2'd1;
						end
					end else if (e_idx == IDX_W'(6)) begin
						t[0] = mk_token(KIND_DEST_SSID, {10'd0, b[4:1]});
						cnt = 2'd1;
						n_cmd = b[7];
					end else if (e_idx < IDX_W'(13)) begin
						if ((b & 8'hfe) != SPACE_SHIFTED) begin
							t[0] = mk_token(KIND_SRC_CHAR, {7'd0, b[7:1]});
							cnt = 2'd1;
						end
					end else begin
						t[0] = mk_token(KIND_SRC_SSID, {10'd0, b[4:1]});
						cnt = 2'd1;
						if (e_cmd != b[7]) begin
							n_ovs = 1'b0;
						end else begin
							n_ovs = 1'b1;
							n_cmd = 1'b0;
						end
						n_aeb = b[0];
						n_boff = '0;
						n_ph = PH_ADDR;
					end
				end
				PH_ADDR: begin
					if (e_boff == '0 && !(!e_aeb && e_bl >= LEN_W'(7))) begin
						t[0] = mk_control(b, e_ovs, e_cmd);
						cnt = 2'd1;
						n_ph = PH_PID;
					end else if (e_boff < 3'd6) begin
						if ((b & 8'hfe) != SPACE_SHIFTED) begin
							t[0] = mk_token(KIND_VIA_CHAR, {7'd0, b[7:1]});
							cnt = 2'd1;
						end
						n_boff = e_boff + 3'd1;
					end else begin
						t[0] = mk_token(KIND_VIA_SSID, {10'd0, b[4:1]});
						cnt = 2'd1;
						n_aeb = b[0];
						n_boff = '0;
					end
				end
				PH_CTRL: begin
					t[0] = mk_control(b, e_ovs, e_cmd);
					cnt = 2'd1;
					n_ph = PH_PID;
				end
				PH_PID: begin
					t[0] = mk_token(KIND_PID, {6'd0, b});
					cnt = 2'd1;
					n_ph = PH_DATA;
				end
				default: begin
					t[0] = mk_token(KIND_PAYLOAD, {6'd0, b});
					cnt = 2'd1;
				end
			endcase
			n_held = b;
			n_idx = e_idx + IDX_W'(1);
			n_bl = e_bl - LEN_W'(1);
			if (n_bl == '0) begin
				n_ph = PH_IDLE;
			end
		end
		grp.count = cnt;
		grp.toks = t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			bl_q <= '0;
			ph_q <= PH_IDLE;
			held_q <= '0;
			fbc_q <= '0;
			ovs_q <= 1'b1;
			cmd_q <= 1'b0;
			aeb_q <= 1'b0;
			boff_q <= '0;
			qso_q <= '0;
		end else if (accept) begin
			idx_q <= n_idx;
			bl_q <= n_bl;
			ph_q <= n_ph;
			held_q <= n_held;
			fbc_q <= n_fbc;
			ovs_q <= n_ovs;
			cmd_q <= n_cmd;
			aeb_q <= n_aeb;
			boff_q <= n_boff;
			qso_q <= n_qso;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/ax25fhp_emit.sv
`default_nettype none
module ax25fhp_emit (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            accept,
	input  ax25fhp_pkg::group_t  grp,
	output logic                 in_ready,
	ax25fhp_token_if.source      tokens
);
	import ax25fhp_pkg::*;

	token_t [MAX_TOKENS-1:0] slots_q;
	logic [1:0]              cnt_q;
	logic                    pop;

	assign pop = tokens.valid && tokens.ready;
	assign in_ready = (cnt_q == 2'd0) || (cnt_q == 2'd1 && tokens.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (accept) begin
			cnt_q <= grp.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// advance: shift the next pending token into the head slot
	always_ff @(posedge clk) begin
		if (accept) begin
			slots_q <= grp.toks;
		end else if (pop) begin
			slots_q[0] <= slots_q[1];
			slots_q[1] <= slots_q[2];
		end
	end

	assign tokens.valid       = (cnt_q != 2'd0);
	assign tokens.token_kind  = slots_q[0].kind;
	assign tokens.token_value = slots_q[0].value;
	assign tokens.frame_kind  = slots_q[0].frame_kind;
	assign tokens.recv_seq    = slots_q[0].recv_seq;
	assign tokens.send_seq    = slots_q[0].send_seq;
	assign tokens.poll_final  = slots_q[0].poll_final;
	assign tokens.version_one = slots_q[0].version_one;
	assign tokens.is_command  = slots_q[0].is_command;
	assign tokens.control_raw = slots_q[0].control_raw;
	assign tokens.last_of_run = (cnt_q == 2'd1);

endmodule
`default_nettype wire

>>> rtl/core/ax25_frame_header_parser.sv
`default_nettype none
// AX.25 header parser: takes one frame byte per beat (frame_length sampled with
// first_of_frame) and returns a token beat for each non-blank address character,
// SSID, QSO number, control byte, PID and payload byte, in byte order. A byte
// yields zero to three tokens; the token buffer drains one token per cycle while
// tokens.ready is high. A new byte is taken in the same cycle the last buffered
// token of the previous byte leaves. last_of_run marks the final token of each
// byte.
module ax25_frame_header_parser #(
	parameter int MAX_FRAME_BYTES = ax25fhp_pkg::MAX_FRAME_BYTES_DEF
) (
	input wire logic         clk,
	input wire logic         arst_n,
	ax25fhp_byte_if.sink     frame,
	ax25fhp_token_if.source  tokens
);
	import ax25fhp_pkg::*;

	group_t grp;
	logic   in_ready;
	logic   accept;

	assign frame.ready = in_ready;
	assign accept = frame.valid && in_ready;

	ax25fhp_parse #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.data_byte     (frame.data_byte),
		.first_of_frame(frame.first_of_frame),
		.frame_length  (frame.frame_length),
		.grp           (grp)
	);

	ax25fhp_emit u_emit (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.grp     (grp),
		.in_ready(in_ready),
		.tokens  (tokens)
	);

endmodule
`default_nettype wire

>>> sim/ax25_frame_header_parser_test.sv
`timescale 1ns / 1ps
module ax25_frame_header_parser_test;
	import ax25fhp_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_STALL = 400;

	typedef struct packed {
		logic        first;
		logic [10:0] len;
		logic [7:0]  data;
		logic        fixed_exp;
		logic [1:0]  n_toks;
		logic [3:0]  kind;
		logic [13:0] value;
	} beat_t;

	typedef struct packed {
		token_t tok;
		logic   last;
	} exp_token_t;

	localparam beat_t DIRECTED_BEATS [0:18] = '{
		'{1'b0, 11'd0, 8'hff, 1'b1, 2'd0, KIND_DEST_CHAR, 14'h0},
		'{1'b1, 11'd7, 8'h00, 1'b1, 2'd0, KIND_DEST_CHAR, 14'h0},
		'{1'b0, 11'd0, 8'hff, 1'b1, 2'd0, KIND_DEST_CHAR, 14'h0},
		'{1'b1, 11'd8, 8'hff, 1'b1, 2'd0, KIND_DEST_CHAR, 14'h0},
		'{1'b0, 11'd0, 8'h03, 1'b1, 2'd0, KIND_DEST_CHAR, 14'h0},
		'{1'b0, 11'd0, 8'h00, 1'b1, 2'd0, KIND_DEST_CHAR, 14'h0},
		'{1'b0, 11'd0, 8'hff, 1'b0, 2'd0, KIND_DEST_CHAR, 14'h0},
		'{1'b0, 11'd0, 8'h5a, 1'b0, 2'd0, KIND_DEST_CHAR, 14'h0},
		'{1'b0, 11'd0, 8'hc3, 1'b0, 2'd0, KIND_DEST_CHAR, 14'h0},
		'{1'b0, 11'd0, 8'h7e, 1'b0, 2'd0, KIND_DEST_CHAR, 14'h0},
		'{1'b0, 11'd0, 8'h2f, 1'b0, 2'd0, KIND_DEST_CHAR, 14'h0},
		'{1'b0, 11'd0, 8'h55, 1'b1, 2'd0, KIND_DEST_CHAR, 14'h0},
		'{1'b1, 11'd2047, 8'hff, 1'b1, 2'd0, KIND_DEST_CHAR, 14'h0},
		'{1'b0, 11'd0, 8'h40, 1'b1, 2'd1, KIND_DEST_CHAR, 14'h7f},
		'{1'b0, 11'd0, 8'h00, 1'b1, 2'd1, KIND_DEST_CHAR, 14'h0},
		'{1'b0, 11'd0, 8'h41, 1'b1, 2'd0, KIND_DEST_CHAR, 14'h0},
		'{1'b1, 11'd14, 8'h96, 1'b1, 2'd0, KIND_DEST_CHAR, 14'h0},
		'{1'b0, 11'd0, 8'h88, 1'b1, 2'd0, KIND_DEST_CHAR, 14'h0},
		'{1'b1, 11'd0, 8'h00, 1'b1, 2'd0, KIND_DEST_CHAR, 14'h0}
	};

	logic clk;
	logic arst_n;

	ax25fhp_byte_if byte_bus ();
	ax25fhp_token_if tok_bus ();

	ax25_frame_header_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.frame(byte_bus),
		.tokens(tok_bus)
	);

	beat_t beat_info;
	exp_token_t token_q [$];
	exp_token_t byte_toks [$];
	int fail_count;
	int parsed_beats;
	int cycle_count;
	int send_idle_pct;
	int recv_idle_pct;
	bit stall_request;

	logic [10:0] p_index;
	logic [10:0] p_left;
	phase_t      p_phase;
	logic [7:0]  p_held;
	logic [7:0]  p_first;
	logic        p_oldver;
	logic        p_cmd;
	logic        p_ext;
	logic [2:0]  p_blk;
	logic [13:0] p_qso;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic void emit(input logic [3:0] kind, input logic [13:0] value);
		exp_token_t e;
		e = '0;
		e.tok.kind = kind;
		e.tok.value = value;
		byte_toks.push_back(e);
	endfunction

	function automatic void addr_char(input logic [3:0] kind, input logic [7:0] b8);
		if ((b8 & 8'hfe) != SPACE_SHIFTED)
			emit(kind, {7'd0, b8[7:1]});
	endfunction

	function automatic void comp_char(input logic [5:0] c);
		if (c != 6'd0)
			emit(KIND_DEST_CHAR, {8'd0, c} + COMP_CHAR_OFFSET);
	endfunction

	function automatic void predict_control(input logic [7:0] c);
		exp_token_t e;
		e = '0;
		e.tok.kind = KIND_CONTROL;
		e.tok.value = {6'd0, c};
		e.tok.poll_final = c[4];
		e.tok.version_one = p_oldver;
		e.tok.is_command = p_cmd & ~p_oldver;
		if (!c[0]) begin
			e.tok.frame_kind = FK_I;
			e.tok.recv_seq = c[7:5];
			e.tok.send_seq = c[3:1];
			e.tok.control_raw = c;
		end else if (c[1]) begin
			e.tok.control_raw = {c[7:5], 1'b0, c[3:0]};
			case (e.tok.control_raw)
				U_UI: e.tok.frame_kind = FK_UI;
				U_SABM: e.tok.frame_kind = FK_SABM;
				U_DISC: e.tok.frame_kind = FK_DISC;
				U_DM: e.tok.frame_kind = FK_DM;
				U_UA: e.tok.frame_kind = FK_UA;
				U_FRMR: e.tok.frame_kind = FK_FRMR;
				default: e.tok.frame_kind = FK_U_UNK;
			endcase
		end else begin
			e.tok.control_raw = {4'd0, c[3:0]};
			e.tok.recv_seq = c[7:5];
			case (c[3:0])
				S_RR: e.tok.frame_kind = FK_RR;
				S_RNR: e.tok.frame_kind = FK_RNR;
				S_REJ: e.tok.frame_kind = FK_REJ;
				default: e.tok.frame_kind = FK_S_UNK;
			endcase
		end
		byte_toks.push_back(e);
	endfunction

	function automatic bit parse_byte(input logic first, input logic [10:0] len,
			input logic [7:0] b8);
		exp_token_t e;
		byte_toks.delete();
		if (first) begin
			p_left = len;
			p_index = '0;
			p_oldver = 1'b1;
			p_cmd = 1'b0;
			p_ext = 1'b0;
			p_blk = '0;
			p_qso = '0;
			p_phase = (len < 11'd8) ? PH_IDLE : PH_HDR;
		end
		if (p_phase == PH_IDLE || p_left == 11'd0) begin
			p_phase = PH_IDLE;
			return 1'b0;
		end
		case (p_phase)
			PH_HDR: begin
				if (p_index == 11'd0) begin
					p_first = b8;
				end else if (b8[0]) begin
					p_oldver = 1'b0;
					p_cmd = b8[1];
					p_qso = {p_first, b8[7:2]};
					p_phase = PH_COMP;
				end else if (p_left < 11'd14) begin
					p_phase = PH_IDLE;
				end else begin
					addr_char(KIND_DEST_CHAR, p_first);
					addr_char(KIND_DEST_CHAR, b8);
					p_phase = PH_NORM;
				end
			end
			PH_COMP: begin
				case (p_index)
					11'd2: comp_char(b8[7:2]);
					11'd3: comp_char({p_held[1:0], b8[7:4]});
					11'd4: begin
						comp_char({p_held[3:0], b8[7:6]});
						comp_char(b8[5:0]);
					end
					11'd5: comp_char(b8[7:2]);
					default: begin
						comp_char({p_held[1:0], b8[7:4]});
						emit(KIND_DEST_SSID, {10'd0, b8[3:0]});
						emit(KIND_QSO, p_qso);
						p_phase = PH_CTRL;
					end
				endcase
			end
			PH_NORM: begin
				if (p_index < 11'd6) begin
					addr_char(KIND_DEST_CHAR, b8);
				end else if (p_index == 11'd6) begin
					emit(KIND_DEST_SSID, {10'd0, b8[4:1]});
					p_cmd = b8[7];
				end else if (p_index < 11'd13) begin
					addr_char(KIND_SRC_CHAR, b8);
				end else begin
					emit(KIND_SRC_SSID, {10'd0, b8[4:1]});
					if (p_cmd != b8[7]) begin
						p_oldver = 1'b0;
					end else begin
						p_oldver = 1'b1;
						p_cmd = 1'b0;
					end
					p_ext = b8[0];
					p_blk = '0;
					p_phase = PH_ADDR;
				end
			end
			PH_ADDR: begin
				if (p_blk == 3'd0 && !(p_ext == 1'b0 && p_left >= 11'd7)) begin
					predict_control(b8);
					p_phase = PH_PID;
				end else if (p_blk < 3'd6) begin
					addr_char(KIND_VIA_CHAR, b8);
					p_blk = p_blk + 3'd1;
				end else begin
					emit(KIND_VIA_SSID, {10'd0, b8[4:1]});
					p_ext = b8[0];
					p_blk = '0;
				end
			end
			PH_CTRL: begin
				predict_control(b8);
				p_phase = PH_PID;
			end
			PH_PID: begin
				emit(KIND_PID, {6'd0, b8});
				p_phase = PH_DATA;
			end
			default: emit(KIND_PAYLOAD, {6'd0, b8});
		endcase
		p_held = b8;
		p_index = p_index + 11'd1;
		p_left = p_left - 11'd1;
		if (p_left == 11'd0)
			p_phase = PH_IDLE;
		if (byte_toks.size() > 0) begin
			e = byte_toks.pop_back();
			e.last = 1'b1;
			byte_toks.push_back(e);
		end
		return 1'b1;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			fail_count++;
			if (fail_count <= 100)
				$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
		end
	endfunction

	always @(posedge clk) begin
		exp_token_t want;
		if (arst_n) begin
			if (byte_bus.valid && byte_bus.ready) begin
				void'(parse_byte(byte_bus.first_of_frame, byte_bus.frame_length,
					byte_bus.data_byte));
				parsed_beats++;
				if (beat_info.fixed_exp) begin
					if (beat_info.n_toks != 2'd0) begin
						want = '0;
						want.tok.kind = beat_info.kind;
						want.tok.value = beat_info.value;
						want.last = 1'b1;
						token_q.push_back(want);
					end
				end else begin
					for (int k = 0; k < byte_toks.size(); k++)
						token_q.push_back(byte_toks[k]);
				end
			end
			if (tok_bus.valid && tok_bus.ready) begin
				if (token_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 100)
						$error("token_kind: expected none, got 0x%0h (token_value 0x%0h)",
							tok_bus.token_kind, tok_bus.token_value);
				end else begin
					want = token_q.pop_front();
					check_field("token_kind", 32'(want.tok.kind), 32'(tok_bus.token_kind));
					check_field("token_value", 32'(want.tok.value),
						32'(tok_bus.token_value));
					check_field("frame_kind", 32'(want.tok.frame_kind),
						32'(tok_bus.frame_kind));
					check_field("recv_seq", 32'(want.tok.recv_seq), 32'(tok_bus.recv_seq));
					check_field("send_seq", 32'(want.tok.send_seq), 32'(tok_bus.send_seq));
					check_field("poll_final", 32'(want.tok.poll_final),
						32'(tok_bus.poll_final));
					check_field("version_one", 32'(want.tok.version_one),
						32'(tok_bus.version_one));
					check_field("is_command", 32'(want.tok.is_command),
						32'(tok_bus.is_command));
					check_field("control_raw", 32'(want.tok.control_raw),
						32'(tok_bus.control_raw));
					check_field("last_of_run", 32'(want.last), 32'(tok_bus.last_of_run));
				end
			end
		end
	end

	initial begin
		tok_bus.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (stall_request) begin
				stall_request = 1'b0;
				tok_bus.ready <= 1'b0;
				repeat (LONG_STALL) @(posedge clk);
			end
			tok_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic sender_idle();
		while ($urandom_range(99) < send_idle_pct) begin
			byte_bus.valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic send_beat(input beat_t bt);
		byte_bus.valid <= 1'b1;
		byte_bus.first_of_frame <= bt.first;
		byte_bus.frame_length <= bt.len;
		byte_bus.data_byte <= bt.data;
		beat_info <= bt;
		do @(posedge clk); while (!byte_bus.ready);
	endtask

	task automatic drain();
		byte_bus.valid <= 1'b0;
		@(posedge clk);
		while (token_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] addr_char_byte();
		case ($urandom_range(5))
			0: return SPACE_SHIFTED;
			1: return SPACE_SHIFTED | 8'h01;
			2: return 8'($urandom);
			default: return {7'($urandom_range(8'h30, 8'h5a)), 1'b0};
		endcase
	endfunction

	function automatic logic [7:0] control_byte();
		logic [7:0] c;
		c = 8'($urandom);
		case ($urandom_range(3))
			0: c[0] = 1'b0;
			1: c[1:0] = 2'b01;
			2: begin
				case ($urandom_range(5))
					0: c = U_UI;
					1: c = U_SABM;
					2: c = U_DISC;
					3: c = U_DM;
					4: c = U_UA;
					default: c = U_FRMR;
				endcase
				c[4] = 1'($urandom);
			end
			default: c[1:0] = 2'b11;
		endcase
		return c;
	endfunction

	task automatic send_random_frame();
		logic [7:0] fb [$];
		logic [7:0] ssid;
		logic [10:0] len;
		int nvia;
		int npay;
		int pick;
		int k;
		beat_t bt;
		pick = $urandom_range(99);
		if (pick < 8) begin
			repeat ($urandom_range(1, 6)) begin
				bt = '0;
				bt.first = ($urandom_range(3) == 0);
				bt.len = 11'($urandom);
				bt.data = 8'($urandom);
				sender_idle();
				send_beat(bt);
			end
			return;
		end
		if (pick < 35) begin
			fb.push_back(8'($urandom));
			fb.push_back(8'($urandom) | 8'h01);
			repeat (5) fb.push_back(8'($urandom));
		end else begin
			nvia = ($urandom_range(2) == 0) ? $urandom_range(1, 3) : 0;
			for (k = 0; k < 2 + nvia; k++) begin
				repeat (6) fb.push_back(addr_char_byte());
				ssid = 8'($urandom);
				if (k > 0)
					ssid[0] = (k == 1 + nvia);
				if ($urandom_range(9) == 0)
					ssid[0] = ~ssid[0];
				fb.push_back(ssid);
			end
		end
		fb.push_back(control_byte());
		if ($urandom_range(4) != 0)
			fb.push_back($urandom_range(1) ? 8'hf0 : 8'($urandom));
		npay = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 8);
		repeat (npay) fb.push_back(8'($urandom));
		pick = $urandom_range(99);
		if (pick < 75)
			len = 11'(fb.size());
		else if (pick < 90)
			len = 11'($urandom_range(0, fb.size()));
		else
			len = 11'($urandom_range(fb.size(), 2047));
		for (k = 0; k < fb.size(); k++) begin
			bt = '0;
			bt.first = (k == 0);
			bt.len = (k == 0) ? len : 11'($urandom);
			bt.data = fb[k];
			sender_idle();
			send_beat(bt);
		end
	endtask

	initial begin
		byte_bus.valid = 1'b0;
		byte_bus.first_of_frame = 1'b0;
		byte_bus.frame_length = '0;
		byte_bus.data_byte = '0;
		beat_info = '0;
		p_index = '0;
		p_left = '0;
		p_phase = PH_IDLE;
		p_held = '0;
		p_first = '0;
		p_oldver = 1'b1;
		p_cmd = 1'b0;
		p_ext = 1'b0;
		p_blk = '0;
		p_qso = '0;
		send_idle_pct = 13;
		recv_idle_pct = 61;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < $size(DIRECTED_BEATS); k++) begin
			sender_idle();
			send_beat(DIRECTED_BEATS[k]);
		end
		while (parsed_beats < 150)
			send_random_frame();
		drain();

		send_idle_pct = 61;
		recv_idle_pct = 13;
		while (parsed_beats < 300)
			send_random_frame();
		drain();

		// hold the token side while bytes keep coming
		send_idle_pct = 0;
		recv_idle_pct = 0;
		stall_request = 1'b1;
		while (parsed_beats < 340)
			send_random_frame();
		while (parsed_beats < 450)
			send_random_frame();
		drain();

		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
